// File: rtl/fsq_pkg.sv
// ----------------------------------------------------------------------------
// fsq_pkg: shared types and functions of the four-square cipher
// row-order tables and symbol mapping for pair substitution over 8x8 grids
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam int unsigned SymW   = 6;
  localparam int unsigned CharW  = 7;
  localparam int unsigned RowW   = 3;
  localparam int unsigned NumRow = 8;
  localparam int unsigned KeyW   = RowW * NumRow;
  localparam int unsigned IdxW   = 2;

  localparam logic [KeyW-1:0] FirstKeyReset  = 24'd19117;
  localparam logic [KeyW-1:0] SecondKeyReset = 24'd31404;

  typedef enum logic [IdxW-1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_FIRST_KEY    = 2'd1,
    REG_SECOND_KEY   = 2'd2
  } reg_idx_t;

  typedef logic [KeyW-1:0] row_tab_t;

  typedef struct packed {
    logic     decrypt;
    row_tab_t ord1;
    row_tab_t inv1;
    row_tab_t ord2;
    row_tab_t inv2;
  } key_state_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             pair_last;
  } result_t;

  function automatic logic [RowW-1:0] tab_get(row_tab_t tab, logic [RowW-1:0] k);
    tab_get = tab[k*RowW +: RowW];
  endfunction

  // sequential swaps of entries i and i + shift i (modulo 8)
  function automatic row_tab_t make_order(logic [KeyW-1:0] shifts);
    logic [RowW-1:0] ord [NumRow];
    logic [RowW-1:0] j;
    logic [RowW-1:0] t;
    row_tab_t        res;
    for (int i = 0; i < NumRow; i++) begin
      ord[i] = RowW'(i);
    end
    for (int i = 0; i < NumRow; i++) begin
      j      = RowW'(i) + shifts[i*RowW +: RowW];
      t      = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
    for (int i = 0; i < NumRow; i++) begin
      res[i*RowW +: RowW] = ord[i];
    end
    make_order = res;
  endfunction

  function automatic row_tab_t invert_order(row_tab_t ord);
    row_tab_t res;
    res = '0;
    for (int i = 0; i < NumRow; i++) begin
      res[ord[i*RowW +: RowW]*RowW +: RowW] = RowW'(i);
    end
    invert_order = res;
  endfunction

  // uppercase a-z, then fold to a 6-bit symbol; decrypt offsets by 32
  function automatic logic [SymW-1:0] to_symbol(logic [CharW-1:0] code, logic decrypt);
    logic [CharW-1:0] c;
    c = code;
    if (code >= 7'd97 && code <= 7'd122) begin
      c = code - 7'd32;
    end
    to_symbol = {c[SymW-1] ^ decrypt, c[SymW-2:0]};
  endfunction

  function automatic logic [CharW-1:0] to_char(logic [SymW-1:0] sym);
    to_char = {1'b0, sym} + 7'd32;
  endfunction

endpackage

// File: rtl/fsq_if.sv
// ----------------------------------------------------------------------------
// fsq channel interfaces
// valid/ready channels for input characters, results and register writes
// ----------------------------------------------------------------------------
interface fsq_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsq_pkg::CharW-1:0]   char_code;
  logic                        msg_end;

  modport source (output valid, output char_code, output msg_end, input ready);
  modport sink   (input valid, input char_code, input msg_end, output ready);
endinterface

interface fsq_out_if;
  logic                        valid;
  logic                        ready;
  logic [fsq_pkg::CharW-1:0]   out_char;
  logic                        pair_last;

  modport source (output valid, output out_char, output pair_last, input ready);
  modport sink   (input valid, input out_char, input pair_last, output ready);
endinterface

interface fsq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fsq_pkg::IdxW-1:0]    index;
  logic [fsq_pkg::KeyW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/foursquare_cipher_8x8.sv
// ----------------------------------------------------------------------------
// foursquare_cipher_8x8: four-square substitution over 8x8 symbol grids
//
// in_ch takes one 7-bit character per request, msg_end marking the last
// character of a message. The first symbol of a pair is held; the second
// one pushes two results into a four-entry output queue in the same cycle.
// out_ch delivers one character per request, pair_last high on the second.
// The results of a pair are written into the queue on the request that
// completes the pair. Throughput: one input request per cycle while in_ch is
// ready; a message end on an unpaired symbol in encrypt mode yields two results at
// once, so the queue may hold in_ch back.
// cfg writes decrypt_mode (0), first_key_shifts (1), second_key_shifts (2);
// it is always ready and key tables are rebuilt in the write cycle.
// in_ch.ready is low while fewer than two queue entries are free, so a
// stalled receiver backs up into in_ch without loss.
// Reset clears the held symbol, the queue and restores the default keys.
// ----------------------------------------------------------------------------
module foursquare_cipher_8x8 (
  input  logic       clk,
  input  logic       rst,
  fsq_in_if.sink     in_ch,
  fsq_out_if.source  out_ch,
  fsq_cfg_if.sink    cfg
);

  fsq_pkg::key_state_t keys;

  logic [fsq_pkg::SymW-1:0] held_symbol;
  logic                     holding_first;
  logic [fsq_pkg::SymW-1:0] sym;
  logic [fsq_pkg::SymW-1:0] sym_a;
  logic [fsq_pkg::SymW-1:0] sym_b;
  logic [fsq_pkg::RowW-1:0] row1;
  logic [fsq_pkg::RowW-1:0] row2;
  logic                     accept;
  logic                     emit;
  logic                     push;
  logic                     pop;

  fsq_pkg::result_t queue [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       count;
  logic [2:0]       count_next;

  fsq_key_regs u_keys (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .keys (keys)
  );

  assign in_ch.ready = (count <= 3'd2);
  assign accept      = in_ch.valid & in_ch.ready;
  assign sym         = fsq_pkg::to_symbol(in_ch.char_code, keys.decrypt);
  assign emit        = holding_first | (in_ch.msg_end & ~keys.decrypt);
  assign push        = accept & emit;
  assign pop         = out_ch.valid & out_ch.ready;

  // pair operands; an unpaired final symbol is padded with zero
  assign sym_a = holding_first ? held_symbol : sym;
  assign sym_b = holding_first ? sym : '0;

  always_comb begin
    if (keys.decrypt) begin
      row1 = fsq_pkg::tab_get(keys.ord1, sym_a[5:3]);
      row2 = fsq_pkg::tab_get(keys.ord2, sym_b[5:3]);
    end else begin
      row1 = fsq_pkg::tab_get(keys.inv1, sym_a[5:3]);
      row2 = fsq_pkg::tab_get(keys.inv2, sym_b[5:3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding_first <= 1'b0;
      held_symbol   <= '0;
    end else if (accept) begin
      holding_first <= ~holding_first & ~in_ch.msg_end;
      held_symbol   <= sym;
    end
  end

  // output queue
  assign count_next = count + (push ? 3'd2 : 3'd0) - (pop ? 3'd1 : 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd2;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr]        <= '{out_char: fsq_pkg::to_char({row1, sym_b[2:0]}),
                                pair_last: 1'b0};
      queue[wr_ptr + 2'd1] <= '{out_char: fsq_pkg::to_char({row2, sym_a[2:0]}),
                                pair_last: 1'b1};
    end
  end

  assign out_ch.valid     = (count != 3'd0);
  assign out_ch.out_char  = queue[rd_ptr].out_char;
  assign out_ch.pair_last = queue[rd_ptr].pair_last;

endmodule

// File: rtl/fsq_key_regs.sv
// ----------------------------------------------------------------------------
// fsq_key_regs: configuration registers and keyed row tables
// builds row order and inverse of a keyed grid when its key is written
// ----------------------------------------------------------------------------
module fsq_key_regs (
  input  logic                clk,
  input  logic                rst,
  fsq_cfg_if.sink             cfg,
  output fsq_pkg::key_state_t keys
);

  fsq_pkg::row_tab_t new_ord;

  assign cfg.ready = 1'b1;
  assign new_ord   = fsq_pkg::make_order(cfg.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      keys.decrypt <= 1'b0;
      keys.ord1    <= fsq_pkg::make_order(fsq_pkg::FirstKeyReset);
      keys.inv1    <= fsq_pkg::invert_order(fsq_pkg::make_order(fsq_pkg::FirstKeyReset));
      keys.ord2    <= fsq_pkg::make_order(fsq_pkg::SecondKeyReset);
      keys.inv2    <= fsq_pkg::invert_order(fsq_pkg::make_order(fsq_pkg::SecondKeyReset));
    end else if (cfg.valid) begin
      case (cfg.index)
        fsq_pkg::REG_DECRYPT_MODE: begin
          keys.decrypt <= cfg.data[0];
        end
        fsq_pkg::REG_FIRST_KEY: begin
          keys.ord1 <= new_ord;
          keys.inv1 <= fsq_pkg::invert_order(new_ord);
        end
        fsq_pkg::REG_SECOND_KEY: begin
          keys.ord2 <= new_ord;
          keys.inv2 <= fsq_pkg::invert_order(new_ord);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: test/foursquare_cipher_8x8_tb.sv
// ----------------------------------------------------------------------------
// foursquare_cipher_8x8_tb: self-checking regression of the four-square cipher
// a queue-fed driver offers characters, an in-bench predictor tracks the pair
// buffer and the keyed grids, and a monitor checks every output request in
// order; keys and mode change between phases once the output queue is empty
// ----------------------------------------------------------------------------
module foursquare_cipher_8x8_tb;
  import fsq_pkg::*;

  localparam int unsigned          CycleLimit = 200000;
  localparam logic [IdxW-1:0]      REG_SPARE  = 2'd3;
  localparam logic [KeyW-1:0]      KeyOnes    = '1;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } char_req_t;

  typedef logic [NumRow-1:0][RowW-1:0] row_map_t;

  logic clk;
  logic rst;

  fsq_in_if  in_bus ();
  fsq_out_if out_bus ();
  fsq_cfg_if cfg_bus ();

  foursquare_cipher_8x8 dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg    (cfg_bus)
  );

  char_req_t        send_q [$];
  result_t          expected_chars [$];
  int               pushed_count;
  int               accepted_count;
  int               results_seen;
  int               errors;
  int               idle_pct;
  int unsigned      cycles;
  int               hold_left;
  logic             hold_done;
  char_req_t        next_req;
  result_t          got;
  result_t          want;

  // predictor state
  logic             decrypt_on;
  logic [KeyW-1:0]  key_a;
  logic [KeyW-1:0]  key_b;
  logic [SymW-1:0]  held_sym;
  logic             holding;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("foursquare_cipher_8x8 regression: fail");
      $finish;
    end
  end

  function automatic row_map_t row_order(logic [KeyW-1:0] shifts);
    row_map_t        ord;
    logic [RowW-1:0] j;
    logic [RowW-1:0] t;
    for (int i = 0; i < NumRow; i++) ord[i] = RowW'(i);
    for (int i = 0; i < NumRow; i++) begin
      j      = RowW'(i) + shifts[3*i +: 3];
      t      = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
    return ord;
  endfunction

  function automatic row_map_t row_inverse(row_map_t ord);
    row_map_t inv;
    for (int i = 0; i < NumRow; i++) inv[ord[i]] = RowW'(i);
    return inv;
  endfunction

  // decrypt folds (c - 32) mod 64, the same as (c + 32) mod 64
  function automatic logic [SymW-1:0] char_to_sym(logic [CharW-1:0] code, logic dec);
    logic [CharW-1:0] up;
    up = code;
    if (code >= 7'd97 && code <= 7'd122) up = code - 7'd32;
    if (dec) up = up + 7'd32;
    return up[SymW-1:0];
  endfunction

  task automatic substitute_pair(logic [SymW-1:0] a, logic [SymW-1:0] b);
    row_map_t        ord1;
    row_map_t        ord2;
    row_map_t        inv1;
    row_map_t        inv2;
    logic [SymW-1:0] o1;
    logic [SymW-1:0] o2;
    result_t         r;
    ord1 = row_order(key_a);
    ord2 = row_order(key_b);
    inv1 = row_inverse(ord1);
    inv2 = row_inverse(ord2);
    if (!decrypt_on) begin
      o1 = {inv1[a[5:3]], b[2:0]};
      o2 = {inv2[b[5:3]], a[2:0]};
    end else begin
      o1 = {ord1[a[5:3]], b[2:0]};
      o2 = {ord2[b[5:3]], a[2:0]};
    end
    r.out_char  = {1'b0, o1} + 7'd32;
    r.pair_last = 1'b0;
    expected_chars.push_back(r);
    r.out_char  = {1'b0, o2} + 7'd32;
    r.pair_last = 1'b1;
    expected_chars.push_back(r);
  endtask

  task automatic track_pairs(char_req_t req);
    logic [SymW-1:0] sym;
    sym = char_to_sym(req.code, decrypt_on);
    if (holding) begin
      substitute_pair(held_sym, sym);
      holding  = 1'b0;
      held_sym = '0;
    end else if (req.last) begin
      if (!decrypt_on) substitute_pair(sym, '0);
    end else begin
      held_sym = sym;
      holding  = 1'b1;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid     <= 1'b0;
      in_bus.char_code <= '0;
      in_bus.msg_end   <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_pairs('{code: in_bus.char_code, last: in_bus.msg_end});
        accepted_count++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_req          = send_q.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.char_code <= next_req.code;
          in_bus.msg_end   <= next_req.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // one long back-pressure window so the output queue fills up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_left <= 250;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.out_char  = out_bus.out_char;
        got.pair_last = out_bus.pair_last;
        results_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected result: out_char %0d pair_last %0d", got.out_char,
                 got.pair_last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (got.out_char !== want.out_char) begin
            $error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
            errors++;
          end
          if (got.pair_last !== want.pair_last) begin
            $error("pair_last: expected %0d, got %0d", want.pair_last, got.pair_last);
            errors++;
          end
        end
      end
      out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_char(logic [CharW-1:0] code, logic last);
    send_q.push_back('{code: code, last: last});
    pushed_count++;
  endtask

  task automatic drain();
    while (accepted_count != pushed_count || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [KeyW-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_DECRYPT_MODE) decrypt_on = value[0];
    else if (idx == REG_FIRST_KEY) key_a = value;
    else if (idx == REG_SECOND_KEY) key_b = value;
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    case ($urandom_range(3))
      0:       return '0;
      1:       return KeyOnes;
      default: return KeyW'($urandom());
    endcase
  endfunction

  function automatic logic [CharW-1:0] rand_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return CharW'($urandom_range(90, 65));
    if (r < 70) return CharW'($urandom_range(122, 97));
    return CharW'($urandom_range(127, 0));
  endfunction

  // mostly whole messages; some with the end mark scattered at random
  task automatic queue_messages(int n);
    int   count;
    int   len;
    logic noisy;
    count = 0;
    while (count < n) begin
      len   = $urandom_range(12, 1);
      noisy = ($urandom_range(99) < 15);
      for (int k = 0; k < len && count < n; k++) begin
        if (noisy) send_char(rand_char(), 1'($urandom_range(1)));
        else send_char(rand_char(), k == len - 1);
        count++;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    in_bus.valid     = 1'b0;
    in_bus.char_code = '0;
    in_bus.msg_end   = 1'b0;
    out_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    decrypt_on       = 1'b0;
    key_a            = FirstKeyReset;
    key_b            = SecondKeyReset;
    held_sym         = '0;
    holding          = 1'b0;
    pushed_count     = 0;
    accepted_count   = 0;
    results_seen     = 0;
    errors           = 0;
    idle_pct         = 27;
    cycles           = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // encrypt with reset keys: case folding edges, field extremes, padding
    send_char(7'd65, 1'b0);
    send_char(7'd98, 1'b0);
    send_char(7'd0, 1'b0);
    send_char(7'd127, 1'b0);
    send_char(7'd96, 1'b0);
    send_char(7'd123, 1'b0);
    send_char(7'd97, 1'b0);
    send_char(7'd122, 1'b0);
    send_char("E", 1'b0);
    send_char("M", 1'b0);
    send_char("B", 1'b0);
    send_char("E", 1'b0);
    send_char("D", 1'b1);
    send_char(7'd64, 1'b0);
    send_char(7'd31, 1'b1);
    // mode flips while the first symbol of a pair is held
    send_char("Q", 1'b0);
    drain();
    write_reg(REG_DECRYPT_MODE, KeyW'(1));
    send_char("x", 1'b1);
    // decrypt: a lone final symbol is dropped
    send_char("K", 1'b0);
    send_char("9", 1'b0);
    send_char("_", 1'b1);
    send_char("r", 1'b0);
    drain();
    write_reg(REG_DECRYPT_MODE, KeyW'(0));
    write_reg(REG_FIRST_KEY, '0);
    write_reg(REG_SECOND_KEY, KeyOnes);
    send_char("S", 1'b1);
    drain();
    write_reg(REG_FIRST_KEY, KeyOnes);
    write_reg(REG_SECOND_KEY, '0);
    write_reg(REG_SPARE, KeyOnes);
    send_char(7'd32, 1'b0);
    send_char(7'd95, 1'b0);
    send_char("z", 1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      idle_pct <= (p == 4) ? 0 : 27;
      write_reg(REG_DECRYPT_MODE, KeyW'($urandom_range(1)));
      write_reg(REG_FIRST_KEY, rand_key());
      write_reg(REG_SECOND_KEY, rand_key());
      queue_messages((p == 4) ? 150 : 70);
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("foursquare_cipher_8x8 regression: pass");
    end else begin
      $display("foursquare_cipher_8x8 regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fsq_pkg.sv
rtl/fsq_if.sv
rtl/fsq_key_regs.sv
rtl/foursquare_cipher_8x8.sv
test/foursquare_cipher_8x8_tb.sv
